### rtl/core/wfae_pkg.sv
// ----------------------------------------------------------------------------
// wfae_pkg: shared types and tables for the frame airtime estimator
// Work descriptor passed from the classifier to the divide/scale engine,
// and the per-MCS data-bits-per-symbol tables.
// ----------------------------------------------------------------------------
package wfae_pkg;

  localparam int NUM_W     = 20;
  localparam int DIV_W     = 11;
  localparam int SYM_W     = 8;
  localparam int PRE_W     = 10;
  localparam int AIR_W     = 20;
  localparam int DIV_STEPS = NUM_W;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DIV_W-1:0] divisor;
    logic [SYM_W-1:0] sym;
    logic [PRE_W-1:0] pre;
  } entry_t;

  function automatic logic [DIV_W-1:0] ht_ndbps(input logic [2:0] mcs);
    logic [DIV_W-1:0] r;
    case (mcs)
      3'd0:    r = DIV_W'(26);
      3'd1:    r = DIV_W'(52);
      3'd2:    r = DIV_W'(78);
      3'd3:    r = DIV_W'(104);
      3'd4:    r = DIV_W'(156);
      3'd5:    r = DIV_W'(208);
      3'd6:    r = DIV_W'(234);
      default: r = DIV_W'(260);
    endcase
    return r;
  endfunction

  function automatic logic [DIV_W-1:0] he_ndbps(input logic [3:0] mcs);
    logic [DIV_W-1:0] r;
    case (mcs)
      4'd0:    r = DIV_W'(117);
      4'd1:    r = DIV_W'(234);
      4'd2:    r = DIV_W'(351);
      4'd3:    r = DIV_W'(468);
      4'd4:    r = DIV_W'(702);
      4'd5:    r = DIV_W'(936);
      4'd6:    r = DIV_W'(1053);
      4'd7:    r = DIV_W'(1170);
      4'd8:    r = DIV_W'(1404);
      4'd9:    r = DIV_W'(1560);
      4'd10:   r = DIV_W'(1755);
      default: r = DIV_W'(1950);
    endcase
    return r;
  endfunction

endpackage

### rtl/core/wfae_front.sv
// ----------------------------------------------------------------------------
// wfae_front: frame classifier
// Decodes format and signal fields into a descriptor: numerator, divisor,
// symbol time and preamble, so that airtime = pre + ceil-quotient * sym.
// ----------------------------------------------------------------------------
module wfae_front (
  input  logic [3:0]       mode,
  input  logic [7:0]       sig_a1,
  input  logic [15:0]      sig_a2,
  input  logic [15:0]      payload_bytes,
  output wfae_pkg::entry_t entry
);
  import wfae_pkg::*;

  localparam logic [3:0] MODE_DSSS  = 4'd0;
  localparam logic [3:0] MODE_OFDM  = 4'd1;
  localparam logic [3:0] MODE_HT    = 4'd2;
  localparam logic [3:0] MODE_VHT   = 4'd3;
  localparam logic [3:0] MODE_HE_SU = 4'd4;
  localparam logic [3:0] MODE_HE_ER = 4'd5;
  localparam logic [3:0] MODE_HE_TB = 4'd6;
  localparam logic [3:0] MODE_HE_MU = 4'd7;

  logic [NUM_W-1:0] bytes8;
  logic [NUM_W-1:0] bits;
  logic [2:0]       ht_mcs;
  logic [3:0]       he_mcs;
  logic [DIV_W-1:0] ndbps;
  logic [SYM_W-1:0] sym;
  logic [PRE_W-1:0] pre;

  assign bytes8 = NUM_W'({payload_bytes, 3'b000});
  assign bits   = bytes8 + NUM_W'(22);
  assign ht_mcs = (sig_a1[6:0] > 7'd7) ? 3'd7 : sig_a1[2:0];
  assign he_mcs = (sig_a1[3:0] > 4'd11) ? 4'd11 : sig_a1[3:0];

  always_comb begin
    ndbps = DIV_W'(96);
    sym   = SYM_W'(40);
    pre   = PRE_W'(260);
    unique case (mode) inside
      MODE_DSSS, MODE_OFDM: begin
        ndbps = DIV_W'(216);
      end
      MODE_HT: begin
        ndbps = ht_ndbps(ht_mcs);
        sym   = sig_a1[7] ? SYM_W'(36) : SYM_W'(40);
        pre   = PRE_W'(360);
      end
      MODE_VHT: begin
        ndbps = ht_ndbps(3'd7);
        pre   = PRE_W'(360);
      end
      MODE_HE_SU, MODE_HE_ER, MODE_HE_TB: begin
        ndbps = he_ndbps(he_mcs);
        sym   = (sig_a2[13:12] == 2'b11) ? SYM_W'(160) : SYM_W'(136);
        pre   = PRE_W'(440);
      end
      MODE_HE_MU: begin
        ndbps = he_ndbps(4'd7);
        sym   = SYM_W'(136);
        pre   = PRE_W'(520);
      end
      default: begin
        ndbps = DIV_W'(96);
      end
    endcase
  end

  always_comb begin
    if (payload_bytes == 16'd0) begin
      entry.num     = '0;
      entry.divisor = DIV_W'(1);
      entry.sym     = '0;
      entry.pre     = PRE_W'(200);
    end else if (mode == MODE_DSSS) begin
      entry.num     = bytes8 + NUM_W'(10);
      entry.divisor = DIV_W'(11);
      entry.sym     = SYM_W'(10);
      entry.pre     = PRE_W'(960);
    end else begin
      entry.num     = bits + NUM_W'(ndbps) - NUM_W'(1);
      entry.divisor = ndbps;
      entry.sym     = sym;
      entry.pre     = pre;
    end
  end

endmodule

### rtl/core/wfae_queue.sv
// ----------------------------------------------------------------------------
// wfae_queue: descriptor queue
// Small register FIFO decoupling the classifier from the divide engine.
// ----------------------------------------------------------------------------
module wfae_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wfae_pkg::entry_t push_data,
  input  logic             pop,
  output wfae_pkg::entry_t pop_data,
  output logic             full,
  output logic             empty
);
  import wfae_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           store [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/wfae_back.sv
// ----------------------------------------------------------------------------
// wfae_back: divide and scale engine
// Restoring divider, one quotient bit per cycle, then multiply by symbol
// time and add preamble.
// ----------------------------------------------------------------------------
module wfae_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  wfae_pkg::entry_t            head,
  output logic                        pop,
  output logic                        done,
  output logic [wfae_pkg::AIR_W-1:0]  airtime
);
  import wfae_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {IDLE, DIV, MUL, FIN} state_t;

  state_t              state;
  logic [NUM_W-1:0]    quo;
  logic [DIV_W-1:0]    rem;
  logic [DIV_W-1:0]    divisor;
  logic [SYM_W-1:0]    sym;
  logic [PRE_W-1:0]    pre;
  logic [STEP_W-1:0]   step;
  logic [AIR_W-1:0]    product;

  logic [DIV_W:0]      trial;
  logic [DIV_W:0]      diff;
  logic                ge;
  logic [DIV_W-1:0]    rem_next;
  logic [NUM_W+SYM_W-1:0] full_product;

  assign pop          = (state == IDLE) && !empty;
  assign trial        = {rem, quo[NUM_W-1]};
  assign ge           = (trial >= {1'b0, divisor});
  assign diff         = trial - {1'b0, divisor};
  assign rem_next     = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  assign full_product = quo * sym;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (!empty) begin
            quo     <= head.num;
            divisor <= head.divisor;
            sym     <= head.sym;
            pre     <= head.pre;
            rem     <= '0;
            step    <= '0;
            state   <= DIV;
          end
        end
        DIV: begin
          rem  <= rem_next;
          quo  <= {quo[NUM_W-2:0], ge};
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= MUL;
          end
        end
        MUL: begin
          product <= full_product[AIR_W-1:0];
          state   <= FIN;
        end
        FIN: begin
          airtime <= AIR_W'(pre) + product;
          done    <= 1'b1;
          state   <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### rtl/core/wifi_frame_airtime_estimator.sv
// ----------------------------------------------------------------------------
// wifi_frame_airtime_estimator: 802.11 frame airtime estimate, 0.1 us units
// The engine takes a queued item only when idle, runs the 20-step bit-serial divider,
// then scales by symbol time and adds the preamble before it takes the next item.
// Up to QUEUE_DEPTH items wait in the queue; busy is high while it is full.
// Reset empties the queue and idles the divider; results cannot be stalled.
// ----------------------------------------------------------------------------
module wifi_frame_airtime_estimator #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  mode,
  input  logic [7:0]  sig_a1,
  input  logic [15:0] sig_a2,
  input  logic [15:0] payload_bytes,
  output logic        done,
  output logic [19:0] airtime_tenths_us
);
  import wfae_pkg::*;

  entry_t entry;
  entry_t head;
  logic   full;
  logic   empty;
  logic   pop;
  logic   push;

  assign busy = full;
  assign push = start && !full;

  wfae_front u_front (
    .mode          (mode),
    .sig_a1        (sig_a1),
    .sig_a2        (sig_a2),
    .payload_bytes (payload_bytes),
    .entry         (entry)
  );

  wfae_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .pop_data  (head),
    .full      (full),
    .empty     (empty)
  );

  wfae_back u_back (
    .clk     (clk),
    .rst     (rst),
    .empty   (empty),
    .head    (head),
    .pop     (pop),
    .done    (done),
    .airtime (airtime_tenths_us)
  );

endmodule

### tb/tb_wifi_frame_airtime_estimator.sv
// ----------------------------------------------------------------------------
// tb_wifi_frame_airtime_estimator: self-checking bench for the airtime estimator
// Drives a short table of frames (zero payload, size extremes, every format,
// MCS clamping, GI selection, undefined format codes), then random frames
// under several sender idle levels. Each done strobe is checked, oldest item
// first, against the table airtime or an in-bench calculation in 0.1 us units.
// ----------------------------------------------------------------------------
module tb_wifi_frame_airtime_estimator;

  typedef enum logic [3:0] {
    FMT_DSSS     = 4'd0,
    FMT_OFDM     = 4'd1,
    FMT_HT       = 4'd2,
    FMT_VHT      = 4'd3,
    FMT_HE_SU    = 4'd4,
    FMT_HE_ER    = 4'd5,
    FMT_HE_TB    = 4'd6,
    FMT_HE_MU    = 4'd7,
    FMT_UNKNOWN  = 4'd8,
    FMT_RSVD_MAX = 4'd15
  } frame_fmt_e;

  typedef struct packed {
    logic [3:0]  fmt;
    logic [7:0]  a1;
    logic [15:0] a2;
    logic [15:0] bytes;
    logic        typed;
    logic [19:0] airtime;
  } frame_row_t;

  localparam int NUM_ROWS      = 20;
  localparam int NUM_PHASES    = 3;
  localparam int ITEMS_PER_PHASE = 570;
  localparam int DRAIN_CYCLES  = 30;
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [3:0]  mode = '0;
  logic [7:0]  sig_a1 = '0;
  logic [15:0] sig_a2 = '0;
  logic [15:0] payload_bytes = '0;
  logic        busy;
  logic        done;
  logic [19:0] airtime_tenths_us;

  logic        row_typed = 1'b0;
  logic [19:0] row_airtime = '0;

  logic [19:0] pending_airtime[$];
  int          idle_pct = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  int ht_bits_per_symbol[8] = '{26, 52, 78, 104, 156, 208, 234, 260};
  int he_bits_per_symbol[12] = '{117, 234, 351, 468, 702, 936, 1053, 1170,
                                 1404, 1560, 1755, 1950};

  wifi_frame_airtime_estimator dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .mode             (mode),
    .sig_a1           (sig_a1),
    .sig_a2           (sig_a2),
    .payload_bytes    (payload_bytes),
    .done             (done),
    .airtime_tenths_us(airtime_tenths_us)
  );

  always #2 clk = ~clk;

  function automatic int unsigned ofdm_airtime(input int unsigned preamble,
                                               input int unsigned symbol,
                                               input int unsigned ndbps,
                                               input int unsigned bytes);
    int unsigned bits;
    int unsigned nsym;
    bits = 22 + 8 * bytes;
    nsym = (bits + ndbps - 1) / ndbps;
    return preamble + nsym * symbol;
  endfunction

  function automatic logic [19:0] estimate_airtime(input logic [3:0] fmt,
                                                   input logic [7:0] a1,
                                                   input logic [15:0] a2,
                                                   input logic [15:0] bytes);
    int unsigned t;
    int unsigned mcs;
    int unsigned symbol;
    if (bytes == 16'd0) begin
      t = 200;
    end else begin
      case (fmt)
        FMT_DSSS: t = 960 + 10 * ((8 * int'(bytes) + 10) / 11);
        FMT_OFDM: t = ofdm_airtime(260, 40, 216, bytes);
        FMT_HT: begin
          mcs = a1[6:0];
          if (mcs > 7) mcs = 7;
          symbol = a1[7] ? 36 : 40;
          t = ofdm_airtime(360, symbol, ht_bits_per_symbol[mcs], bytes);
        end
        FMT_VHT: t = ofdm_airtime(360, 40, ht_bits_per_symbol[7], bytes);
        FMT_HE_SU, FMT_HE_ER, FMT_HE_TB: begin
          mcs = a1[3:0];
          if (mcs > 11) mcs = 11;
          symbol = (a2[13:12] == 2'd3) ? 160 : 136;
          t = ofdm_airtime(440, symbol, he_bits_per_symbol[mcs], bytes);
        end
        FMT_HE_MU: t = ofdm_airtime(520, 136, he_bits_per_symbol[7], bytes);
        default: t = ofdm_airtime(260, 40, 96, bytes);
      endcase
    end
    return t[19:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [19:0] got,
                                 input logic [19:0] want);
    $display("mismatch at cycle %0d: %s, got %0d, expected %0d",
             cycle_count, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_airtime.size());
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic [19:0] want;
    if (!rst) begin
      if (done) begin
        if (pending_airtime.size() == 0) begin
          report_mismatch("result with no item pending", airtime_tenths_us, '0);
        end else begin
          want = pending_airtime.pop_front();
          results_checked++;
          if (airtime_tenths_us !== want)
            report_mismatch("airtime_tenths_us", airtime_tenths_us, want);
        end
      end
      if (start && !busy) begin
        if (row_typed)
          pending_airtime.push_back(row_airtime);
        else
          pending_airtime.push_back(estimate_airtime(mode, sig_a1, sig_a2,
                                                     payload_bytes));
      end
    end
  end

  task automatic send_item(input logic [3:0] fmt, input logic [7:0] a1,
                           input logic [15:0] a2, input logic [15:0] bytes,
                           input logic typed, input logic [19:0] airtime);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    mode          <= fmt;
    sig_a1        <= a1;
    sig_a2        <= a2;
    payload_bytes <= bytes;
    row_typed     <= typed;
    row_airtime   <= airtime;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  initial begin
    frame_row_t  frame_rows[NUM_ROWS];
    int          phase_idle[NUM_PHASES];
    logic [3:0]  fmt;
    logic [15:0] bytes;
    int          pick;

    frame_rows = '{
      '{FMT_DSSS,     8'h00, 16'h0000, 16'd0,     1'b1, 20'd200},
      '{FMT_HE_MU,    8'hFF, 16'hFFFF, 16'd0,     1'b1, 20'd200},
      '{FMT_RSVD_MAX, 8'hFF, 16'hFFFF, 16'd0,     1'b1, 20'd200},
      '{FMT_DSSS,     8'h00, 16'h0000, 16'd11,    1'b1, 20'd1040},
      '{FMT_DSSS,     8'hFF, 16'hFFFF, 16'd65535, 1'b1, 20'd477580},
      '{FMT_UNKNOWN,  8'h00, 16'h0000, 16'd1,     1'b1, 20'd300},
      '{FMT_HT,       8'h00, 16'h0000, 16'd65535, 1'b1, 20'd807000},
      '{FMT_OFDM,     8'h00, 16'h0000, 16'd1500,  1'b0, 20'd0},
      '{FMT_HT,       8'h87, 16'h0000, 16'd1500,  1'b0, 20'd0},
      '{FMT_HT,       8'hFF, 16'h0000, 16'd1500,  1'b0, 20'd0},
      '{FMT_HT,       8'h08, 16'h0000, 16'd100,   1'b0, 20'd0},
      '{FMT_VHT,      8'h00, 16'h0000, 16'd1500,  1'b0, 20'd0},
      '{FMT_HE_SU,    8'h0B, 16'h3000, 16'd1500,  1'b0, 20'd0},
      '{FMT_HE_SU,    8'h0F, 16'h2FFF, 16'd1500,  1'b0, 20'd0},
      '{FMT_HE_ER,    8'hF0, 16'h0000, 16'd1,     1'b0, 20'd0},
      '{FMT_HE_TB,    8'h05, 16'hFFFF, 16'd65535, 1'b0, 20'd0},
      '{FMT_HE_MU,    8'hFF, 16'h3000, 16'd1500,  1'b0, 20'd0},
      '{FMT_UNKNOWN,  8'h00, 16'h0000, 16'd65535, 1'b0, 20'd0},
      '{FMT_OFDM,     8'h00, 16'h0000, 16'd65535, 1'b0, 20'd0},
      '{FMT_HE_SU,    8'h00, 16'h3000, 16'd65535, 1'b0, 20'd0}
    };
    phase_idle = '{0, 61, 16};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (frame_rows[i])
      send_item(frame_rows[i].fmt, frame_rows[i].a1, frame_rows[i].a2,
                frame_rows[i].bytes, frame_rows[i].typed, frame_rows[i].airtime);

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct = phase_idle[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        fmt  = ($urandom_range(99) < 80) ? 4'($urandom_range(8)) : 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 5)
          bytes = 16'd0;
        else if (pick < 40)
          bytes = 16'($urandom_range(1, 64));
        else if (pick < 85)
          bytes = 16'($urandom_range(1, 2304));
        else
          bytes = 16'($urandom_range(65535));
        send_item(fmt, 8'($urandom_range(255)), 16'($urandom_range(65535)), bytes,
                  1'b0, 20'd0);
      end
    end
    start <= 1'b0;

    while (pending_airtime.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d frames (table rows, then random frames over all 16 format codes)",
             items_sent);
    $display("checked %0d airtime results in %0d cycles, %0d mismatches",
             results_checked, cycle_count, mismatch_count);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### wifi_frame_airtime_estimator.f
rtl/core/wfae_pkg.sv
rtl/core/wfae_front.sv
rtl/core/wfae_queue.sv
rtl/core/wfae_back.sv
rtl/core/wifi_frame_airtime_estimator.sv
tb/tb_wifi_frame_airtime_estimator.sv
